// ----- sv/rbd_pkg.sv -----
// Shared types and constants of the RGB box downscaler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package rbd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_FACTOR = 16;
    localparam int MAX_HEIGHT     = 4096;

    localparam int CFG_W   = 13;                      // width and height register width
    localparam int FAC_W   = 5;                       // shrink factor register width
    localparam int ROW_W   = $clog2(MAX_HEIGHT);      // row counter width
    localparam int HBND_W  = ROW_W + 1;               // row bound width
    localparam int PIX_W   = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FACTOR = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [FAC_W-1:0] RST_FACTOR = 5'd2;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [FAC_W-1:0] shrink_factor;
    } rbd_cfg_t;

    // What the back end must do with one queued pixel.
    typedef struct packed {
        logic first;    // first pixel of its block: overwrite the sums
        logic emit;     // last pixel of its block: produce a mean
        logic last;     // the mean is the final one of the frame
    } rbd_flags_t;

endpackage

// ----- sv/rbd_queue.sv -----
// Small first-in first-out queue between the front and back ends.
// Depends on rbd_pkg for its depth.
`timescale 1ns / 1ps
module rbd_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head_data,
    output logic          full,
    output logic          empty
);
    localparam int PW = $clog2(rbd_pkg::QUEUE_DEPTH);
    localparam int NW = PW + 1;

    logic [DW-1:0] store [rbd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full      = (count_reg == NW'(rbd_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/rbd_front.sv -----
// Front end: raster position tracking and classification of each pixel.
// Depends on rbd_pkg; feeds rbd_queue.
`timescale 1ns / 1ps
module rbd_front #(
    parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rbd_pkg::rbd_cfg_t           cfg,
    input  logic                        cfg_wr,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        q_full,
    output logic                        q_push,
    output logic [$clog2(MAX_WIDTH)-1:0] q_idx,
    output rbd_pkg::rbd_flags_t         q_flags,
    output logic [2*$clog2(MAX_FACTOR):0] area
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int FB = $clog2(MAX_FACTOR);
    localparam int FW = FB + 1;
    localparam int AW = 2 * FB + 1;
    localparam int DN = (WW > rbd_pkg::HBND_W) ? WW : rbd_pkg::HBND_W;
    localparam int RW = rbd_pkg::ROW_W;
    localparam int KW = $clog2(DN);

    typedef enum logic [1:0] {ST_LOAD, ST_CALC, ST_RUN} state_t;
    typedef enum logic [1:0] {PH_W, PH_H, PH_C} phase_t;

    state_t        state_reg;
    phase_t        phase_reg;
    logic [KW-1:0] cnt_reg;
    logic [DN-1:0] num_reg;
    logic [FW-1:0] rem_reg;
    logic [DN-1:0] used_w_reg;
    logic [DN-1:0] used_h_reg;
    logic [AW-1:0] area_reg;
    logic [CW-1:0] pc_reg;
    logic [RW-1:0] pr_reg;
    logic [FB-1:0] cib_reg;
    logic [FB-1:0] rib_reg;
    logic [FB-1:0] pc_rem_reg;
    logic [CW-1:0] col_blk_reg;

    logic [DN-1:0]    w_cl;
    logic [DN-1:0]    h_cl;
    logic [FW-1:0]    f_cl;
    logic [FW:0]      trial;
    logic             qbit;
    logic [FW-1:0]    rem_next;
    logic [DN-1:0]    num_next;
    logic [DN+FW-1:0] prod;
    logic [2*FW-1:0]  fsq;
    logic             accept;
    logic             in_area;
    logic             col_end;
    logic             row_end;
    logic             cib_end;
    logic             rib_end;
    logic             rem_end;

    always_comb begin
        if (cfg.image_width == '0) begin
            w_cl = DN'(1);
        end else if (DN'(cfg.image_width) > DN'(MAX_WIDTH)) begin
            w_cl = DN'(MAX_WIDTH);
        end else begin
            w_cl = DN'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            h_cl = DN'(1);
        end else if (DN'(cfg.image_height) > DN'(rbd_pkg::MAX_HEIGHT)) begin
            h_cl = DN'(rbd_pkg::MAX_HEIGHT);
        end else begin
            h_cl = DN'(cfg.image_height);
        end
        if (cfg.shrink_factor == '0) begin
            f_cl = FW'(1);
        end else if (32'(cfg.shrink_factor) > MAX_FACTOR) begin
            f_cl = FW'(MAX_FACTOR);
        end else begin
            f_cl = FW'(cfg.shrink_factor);
        end
    end

    // One restoring division step of the shared bound divider.
    always_comb begin
        trial    = {rem_reg, num_reg[DN-1]};
        qbit     = (trial >= {1'b0, f_cl});
        rem_next = qbit ? FW'(trial - {1'b0, f_cl}) : trial[FW-1:0];
        num_next = {num_reg[DN-2:0], qbit};
        prod     = num_next * f_cl;
        fsq      = f_cl * f_cl;
    end

    assign s_ready = (state_reg == ST_RUN) && !q_full;
    assign accept  = s_valid && s_ready;
    assign in_area = (DN'(pc_reg) < used_w_reg) && (DN'(pr_reg) < used_h_reg);
    assign col_end = (DN'(pc_reg) + 1'b1 >= w_cl);
    assign row_end = (DN'(pr_reg) + 1'b1 >= h_cl);
    assign cib_end = (FW'(cib_reg) + 1'b1 >= f_cl);
    assign rib_end = (FW'(rib_reg) + 1'b1 >= f_cl);
    assign rem_end = (FW'(pc_rem_reg) + 1'b1 >= f_cl);

    assign q_push        = accept && in_area;
    assign q_idx         = col_blk_reg;
    assign q_flags.first = (cib_reg == '0) && (rib_reg == '0);
    assign q_flags.emit  = cib_end && rib_end;
    assign q_flags.last  = (DN'(pc_reg) + 1'b1 >= used_w_reg) &&
                           (DN'(pr_reg) + 1'b1 >= used_h_reg);
    assign area          = area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            phase_reg   <= PH_W;
            cnt_reg     <= '0;
            pc_reg      <= '0;
            pr_reg      <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            pc_rem_reg  <= '0;
            col_blk_reg <= '0;
        end else if (cfg_wr) begin
            // New settings: recompute the block bounds and the column block.
            state_reg <= ST_LOAD;
            phase_reg <= PH_W;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    case (phase_reg)
                        PH_W:    num_reg <= w_cl;
                        PH_H:    num_reg <= h_cl;
                        default: num_reg <= DN'(pc_reg);
                    endcase
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == KW'(DN - 1)) begin
                        case (phase_reg)
                            PH_W: begin
                                used_w_reg <= DN'(prod);
                                phase_reg  <= PH_H;
                                state_reg  <= ST_LOAD;
                            end
                            PH_H: begin
                                used_h_reg <= DN'(prod);
                                phase_reg  <= PH_C;
                                state_reg  <= ST_LOAD;
                            end
                            default: begin
                                col_blk_reg <= CW'(num_next);
                                pc_rem_reg  <= FB'(rem_next);
                                area_reg    <= AW'(fsq);
                                state_reg   <= ST_RUN;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (accept) begin
                        if (col_end) begin
                            pc_reg      <= '0;
                            cib_reg     <= '0;
                            pc_rem_reg  <= '0;
                            col_blk_reg <= '0;
                            if (row_end) begin
                                pr_reg  <= '0;
                                rib_reg <= '0;
                            end else begin
                                pr_reg  <= pr_reg + 1'b1;
                                rib_reg <= rib_end ? '0 : rib_reg + 1'b1;
                            end
                        end else begin
                            pc_reg  <= pc_reg + 1'b1;
                            cib_reg <= cib_end ? '0 : cib_reg + 1'b1;
                            if (rem_end) begin
                                pc_rem_reg  <= '0;
                                col_blk_reg <= col_blk_reg + 1'b1;
                            end else begin
                                pc_rem_reg <= pc_rem_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

// ----- sv/rbd_back.sv -----
// Back end: column-block sum store, accumulation and the mean divider.
// Depends on rbd_pkg; drains rbd_queue and drives the result channel.
`timescale 1ns / 1ps
module rbd_back #(
    parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_idx,
    input  logic [3*rbd_pkg::PIX_W-1:0]   q_pix,
    input  rbd_pkg::rbd_flags_t           q_flags,
    input  logic [2*$clog2(MAX_FACTOR):0] area,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rbd_pkg::PIX_W-1:0]     m_red_mean,
    output logic [rbd_pkg::PIX_W-1:0]     m_green_mean,
    output logic [rbd_pkg::PIX_W-1:0]     m_blue_mean,
    output logic                          m_frame_end
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FB = $clog2(MAX_FACTOR);
    localparam int AW = 2 * FB + 1;
    localparam int PW = rbd_pkg::PIX_W;
    // One spare bit over a full block, for blocks stretched by a settings change.
    localparam int SW = PW + 2 * FB + 1;
    localparam int KW = $clog2(SW);

    typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_DIV, ST_OUT} state_t;

    logic [3*SW-1:0] mem [MAX_WIDTH];
    logic [3*SW-1:0] rd_data_reg;

    state_t              state_reg;
    logic [CW-1:0]       idx_reg;
    logic [3*PW-1:0]     pix_reg;
    rbd_pkg::rbd_flags_t flags_reg;
    logic [KW-1:0]       cnt_reg;
    logic [SW-1:0]       num_reg [3];
    logic [AW-1:0]       rem_reg [3];
    logic [PW-1:0]       mean_reg [3];
    logic                frame_end_reg;

    logic [SW-1:0]   sum [3];
    logic [3*SW-1:0] sum_word;
    logic [AW:0]     trial [3];
    logic            qbit [3];
    logic [SW-1:0]   num_next [3];
    logic [AW-1:0]   rem_next [3];
    logic [PW-1:0]   sat [3];
    logic            wr_en;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = (flags_reg.first ? '0 : rd_data_reg[(2-c)*SW +: SW])
                   + SW'(pix_reg[(2-c)*PW +: PW]);
            trial[c]    = {rem_reg[c], num_reg[c][SW-1]};
            qbit[c]     = (trial[c] >= {1'b0, area});
            rem_next[c] = qbit[c] ? AW'(trial[c] - {1'b0, area}) : trial[c][AW-1:0];
            num_next[c] = {num_reg[c][SW-2:0], qbit[c]};
            sat[c]      = (|num_next[c][SW-1:PW]) ? {PW{1'b1}} : num_next[c][PW-1:0];
        end
        sum_word = {sum[0], sum[1], sum[2]};
    end

    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en   = (state_reg == ST_ACC);
    assign m_valid = (state_reg == ST_OUT);

    assign m_red_mean   = mean_reg[0];
    assign m_green_mean = mean_reg[1];
    assign m_blue_mean  = mean_reg[2];
    assign m_frame_end  = frame_end_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_data_reg <= mem[q_idx];
        end
        if (wr_en) begin
            mem[idx_reg] <= sum_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        idx_reg   <= q_idx;
                        pix_reg   <= q_pix;
                        flags_reg <= q_flags;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (flags_reg.emit) begin
                        for (int c = 0; c < 3; c++) begin
                            num_reg[c] <= sum[c];
                            rem_reg[c] <= '0;
                        end
                        cnt_reg       <= '0;
                        frame_end_reg <= flags_reg.last;
                        state_reg     <= ST_DIV;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    for (int c = 0; c < 3; c++) begin
                        num_reg[c] <= num_next[c];
                        rem_reg[c] <= rem_next[c];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == KW'(SW - 1)) begin
                        for (int c = 0; c < 3; c++) begin
                            mean_reg[c] <= sat[c];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/rgb_box_downscaler_unit.sv -----
// Throughput: the front end takes one pixel per cycle until its four-entry queue fills;
// the back end reads the sum store, then writes it, for each pixel, and on each block's
// last pixel it also divides each channel's sum by the block area bit by bit and takes no
// new pixel until that mean has been taken. Reset is synchronous and active low; after
// it, and after every register write, the front end runs three divisions for the bounds.
// The sum store is not cleared: each entry is written at a block's first row before use.
`timescale 1ns / 1ps
module rgb_box_downscaler_unit #(
    parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbd_pkg::APB_AW-1:0]  paddr,
    input  logic [rbd_pkg::APB_DW-1:0]  pwdata,
    output logic [rbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rbd_pkg::PIX_W-1:0]   s_red_in,
    input  logic [rbd_pkg::PIX_W-1:0]   s_green_in,
    input  logic [rbd_pkg::PIX_W-1:0]   s_blue_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rbd_pkg::PIX_W-1:0]   m_red_mean,
    output logic [rbd_pkg::PIX_W-1:0]   m_green_mean,
    output logic [rbd_pkg::PIX_W-1:0]   m_blue_mean,
    output logic                        m_frame_end
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = 2 * $clog2(MAX_FACTOR) + 1;
    localparam int PXW = 3 * rbd_pkg::PIX_W;
    localparam int DW = CW + PXW + 3;

    rbd_pkg::rbd_cfg_t   cfg_reg;
    logic                cfg_wr;
    logic [1:0]          reg_index;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [CW-1:0]       f_idx;
    rbd_pkg::rbd_flags_t f_flags;
    logic [DW-1:0]       head;
    logic [AW-1:0]       area;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_wr    = psel && penable && pwrite;

    always_comb begin
        case (reg_index)
            rbd_pkg::REG_WIDTH:  prdata = rbd_pkg::APB_DW'(cfg_reg.image_width);
            rbd_pkg::REG_HEIGHT: prdata = rbd_pkg::APB_DW'(cfg_reg.image_height);
            rbd_pkg::REG_FACTOR: prdata = rbd_pkg::APB_DW'(cfg_reg.shrink_factor);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= rbd_pkg::RST_WIDTH;
            cfg_reg.image_height  <= rbd_pkg::RST_HEIGHT;
            cfg_reg.shrink_factor <= rbd_pkg::RST_FACTOR;
        end else if (cfg_wr) begin
            case (reg_index)
                rbd_pkg::REG_WIDTH:  cfg_reg.image_width <= pwdata[rbd_pkg::CFG_W-1:0];
                rbd_pkg::REG_HEIGHT: cfg_reg.image_height <= pwdata[rbd_pkg::CFG_W-1:0];
                rbd_pkg::REG_FACTOR: cfg_reg.shrink_factor <= pwdata[rbd_pkg::FAC_W-1:0];
                default: ;
            endcase
        end
    end

    rbd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cfg_wr  (cfg_wr),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_idx   (f_idx),
        .q_flags (f_flags),
        .area    (area)
    );

    rbd_queue #(
        .DW (DW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_idx, s_red_in, s_green_in, s_blue_in, f_flags}),
        .pop       (q_pop),
        .head_data (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rbd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_idx        (head[DW-1 -: CW]),
        .q_pix        (head[PXW+2 : 3]),
        .q_flags      (head[2:0]),
        .area         (area),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_mean   (m_red_mean),
        .m_green_mean (m_green_mean),
        .m_blue_mean  (m_blue_mean),
        .m_frame_end  (m_frame_end)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the RGB box downscaler: frames and pixel runs are
// streamed under several geometries, and every mean is checked against a
// cycle-free model kept here. Depends on rbd_pkg and rgb_box_downscaler_unit.
`timescale 1ns / 1ps

typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
} block_mean_t;

class mean_scoreboard;
    int unsigned sums[4096][3];
    int unsigned col, row, col_in_blk, row_in_blk;
    int unsigned cfg_width, cfg_height, cfg_factor;
    block_mean_t pending_means[$];
    int errors;

    function new();
        col = 0; row = 0; col_in_blk = 0; row_in_blk = 0;
        cfg_width = 640; cfg_height = 480; cfg_factor = 2;
        errors = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            rbd_pkg::REG_WIDTH:  cfg_width  = value & 32'h1FFF;
            rbd_pkg::REG_HEIGHT: cfg_height = value & 32'h1FFF;
            rbd_pkg::REG_FACTOR: cfg_factor = value & 32'h1F;
            default: ;
        endcase
    endfunction

    // Pixels in one whole frame under the current registers.
    function int unsigned frame_pixels();
        return clamp(cfg_width, 4096) * clamp(cfg_height, 4096);
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w, h, f, used_w, used_h, idx, m;
        int unsigned pix[3];
        block_mean_t res;
        w = clamp(cfg_width, 4096);
        h = clamp(cfg_height, 4096);
        f = clamp(cfg_factor, 16);
        used_w = (w / f) * f;
        used_h = (h / f) * f;
        pix[0] = r; pix[1] = g; pix[2] = b;
        if (col < used_w && row < used_h) begin
            idx = (col / f) % 4096;
            for (int c = 0; c < 3; c++) begin
                if (col_in_blk == 0 && row_in_blk == 0) sums[idx][c] = pix[c];
                else sums[idx][c] += pix[c];
            end
            if (col_in_blk + 1 >= f && row_in_blk + 1 >= f) begin
                m = sums[idx][0] / (f * f); res.red   = (m > 255) ? 8'd255 : m[7:0];
                m = sums[idx][1] / (f * f); res.green = (m > 255) ? 8'd255 : m[7:0];
                m = sums[idx][2] / (f * f); res.blue  = (m > 255) ? 8'd255 : m[7:0];
                res.frame_end = (col + 1 >= used_w && row + 1 >= used_h);
                pending_means.push_back(res);
            end
        end
        if (col_in_blk + 1 >= f) col_in_blk = 0;
        else col_in_blk++;
        if (col + 1 >= w) begin
            col = 0;
            col_in_blk = 0;
            if (row_in_blk + 1 >= f) row_in_blk = 0;
            else row_in_blk++;
            if (row + 1 >= h) begin
                row = 0;
                row_in_blk = 0;
            end else begin
                row++;
            end
        end else begin
            col++;
        end
    endfunction

    function void check_mean(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
        block_mean_t exp_mean;
        if (pending_means.size() == 0) begin
            $error("unexpected mean transfer: red %0d green %0d blue %0d", r, g, b);
            errors++;
            return;
        end
        exp_mean = pending_means.pop_front();
        if (r !== exp_mean.red) begin
            $error("red_mean: expected %0d, got %0d", exp_mean.red, r);
            errors++;
        end
        if (g !== exp_mean.green) begin
            $error("green_mean: expected %0d, got %0d", exp_mean.green, g);
            errors++;
        end
        if (b !== exp_mean.blue) begin
            $error("blue_mean: expected %0d, got %0d", exp_mean.blue, b);
            errors++;
        end
        if (fe !== exp_mean.frame_end) begin
            $error("frame_end: expected %0d, got %0d", exp_mean.frame_end, fe);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_red_in = '0, s_green_in = '0, s_blue_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red_mean, m_green_mean, m_blue_mean;
    logic        m_frame_end;

    mean_scoreboard sb = new();
    bit calm = 1'b0;          // no idling on either side while set
    bit hold_request = 1'b0;
    int hold_cycles = 0;
    int pixels_sent = 0;

    always #2 aclk = ~aclk;

    rgb_box_downscaler_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_mean(m_red_mean), .m_green_mean(m_green_mean),
        .m_blue_mean(m_blue_mean), .m_frame_end(m_frame_end)
    );

    // Result side: check each transfer, then decide whether to stall the next cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_mean(m_red_mean, m_green_mean, m_blue_mean, m_frame_end);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 24);
            end
        end
    end

    // The block may still be busy on a pixel that yields no mean, so allow its latency.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_means.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Registers change only once every pixel has left the block.
    task automatic set_geometry(logic [31:0] w, logic [31:0] h, logic [31:0] f);
        drain();
        write_register(rbd_pkg::REG_WIDTH, w);
        write_register(rbd_pkg::REG_HEIGHT, h);
        write_register(rbd_pkg::REG_FACTOR, f);
    endtask

    // Offers one pixel and returns at the edge of its transfer or after an idle gap.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        s_valid    <= 1'b1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(r, g, b);
        pixels_sent++;
        if (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_random(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // kind: 0 random, 1 all white, 2 all black, 3 alternating extremes
    task automatic send_frame(int kind);
        int unsigned n;
        logic [7:0] v;
        n = sb.frame_pixels();
        for (int unsigned i = 0; i < n; i++) begin
            case (kind)
                1: send_pixel(8'hFF, 8'hFF, 8'hFF);
                2: send_pixel(8'h00, 8'h00, 8'h00);
                3: begin
                    v = i[0] ? 8'hFF : 8'h00;
                    send_pixel(v, ~v, v);
                end
                default: send_random(1);
            endcase
        end
    endtask

    // A one-pixel frame wraps every position counter back to the frame origin.
    task automatic realign();
        set_geometry(1, 1, 1);
        send_random(1);
    endtask

    initial begin
        int unsigned f;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry with a frame cut short is never sent; runs cut short are realigned.
        set_geometry(4, 4, 2);
        send_frame(1);
        send_frame(2);
        send_frame(3);
        set_geometry(5, 3, 2);           // trailing column and row are dropped
        send_frame(0);
        set_geometry(0, 0, 0);           // zero registers act as one
        send_frame(0);
        set_geometry(3, 2, 31);          // factor saturates; frame smaller than a block
        send_frame(0);
        set_geometry(16, 16, 16);        // largest block, full-scale mean
        send_frame(1);
        calm = 1'b1;
        set_geometry(8191, 1, 1);        // width saturates, back-to-back traffic
        send_random(64);
        realign();
        calm = 1'b0;
        set_geometry(1, 8191, 1);        // height saturates
        send_random(64);
        realign();

        // Long receiver stall while pixels keep coming, then a pause mid-frame.
        set_geometry(8, 8, 2);
        hold_request = 1'b1;
        send_frame(0);
        for (int i = 0; i < 64; i++) begin
            send_random(1);
            if (i == 31) begin
                s_valid <= 1'b0;
                while (sb.pending_means.size() > 0) @(posedge aclk);
            end
        end
        send_frame(0);

        while (pixels_sent < 1800) begin
            f = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(1, 16);
            set_geometry($urandom_range(1, 24), $urandom_range(1, 16), f);
            calm = ($urandom_range(9) == 0);
            repeat ($urandom_range(1, 2)) send_frame(0);
            calm = 1'b0;
        end
        drain();

        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

// ----- rgb_box_downscaler_unit.f -----
sv/rbd_pkg.sv
sv/rbd_queue.sv
sv/rbd_front.sv
sv/rbd_back.sv
sv/rgb_box_downscaler_unit.sv
test/testbench.sv
